### rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// shared widths, codes and beat types of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int DEPTH  = 128;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int POS_W  = 10;
	localparam int FPOS_W = 11;
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int GRP_N  = 16;
	localparam int GRP_IW = $clog2(GRP_N);
	localparam int N_GRP  = (DEPTH + GRP_N - 1) / GRP_N;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_FIND   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BADPOS   = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef logic signed [31:0] word_t;

	typedef struct packed {
		logic             shift_up;
		logic             shift_down;
		logic             search;
		logic [IDX_W-1:0] pos;
		logic [CNT_W-1:0] count;
		word_t            value;
	} cell_ctrl_t;

	typedef struct packed {
		logic              hit;
		logic [FPOS_W-1:0] where;
	} find_res_t;

endpackage

### rtl/ple_if.sv
// ----------------------------------------------------------------------------
// ple_if
// request and response channels of the positional list engine
// ----------------------------------------------------------------------------
interface ple_req_if import ple_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       func;
	logic [POS_W-1:0] position;
	word_t            value;

	modport source (output valid, func, position, value, input ready);
	modport sink   (input valid, func, position, value, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [FPOS_W-1:0] found_position;
	logic [FPOS_W-1:0] list_length;
	logic              is_empty;

	modport source (output valid, status, found_position, list_length, is_empty, input ready);
	modport sink   (input valid, status, found_position, list_length, is_empty, output ready);
endinterface

### rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// one list entry: takes the new value or its left or right neighbour on a shift and
// registers its compare result for a search
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [IDX_W-1:0] idx,
	input  word_t            left,
	input  word_t            right,
	output word_t            data,
	output logic             match
);

	word_t data_q;
	logic  match_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			if (idx == ctrl.pos) begin
				data_q <= ctrl.value;
			end else if (idx > ctrl.pos) begin
				data_q <= left;
			end
		end else if (ctrl.shift_down && (idx >= ctrl.pos)) begin
			data_q <= right;
		end
		if (ctrl.search) begin
			match_q <= (CNT_W'(idx) < ctrl.count) && (data_q == ctrl.value);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

### rtl/ple_find.sv
// ----------------------------------------------------------------------------
// ple_find
// first-match encoder over the cell compare bits, one registered group level
// ----------------------------------------------------------------------------
module ple_find import ple_pkg::*; (
	input  logic             clk,
	input  logic [DEPTH-1:0] match,
	output find_res_t        res
);

	logic [N_GRP*GRP_N-1:0] match_pad;
	logic [N_GRP-1:0]       grp_any;
	logic [GRP_IW-1:0]      grp_idx [N_GRP];
	logic [N_GRP-1:0]       grp_any_s2;
	logic [GRP_IW-1:0]      grp_idx_s2 [N_GRP];

	assign match_pad = (N_GRP*GRP_N)'(match);

	always_comb begin
		for (int g = 0; g < N_GRP; g++) begin
			grp_any[g] = |match_pad[g*GRP_N +: GRP_N];
			grp_idx[g] = '0;
			for (int b = GRP_N - 1; b >= 0; b--) begin
				if (match_pad[g*GRP_N + b]) begin
					grp_idx[g] = GRP_IW'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_s2 <= grp_any;
		grp_idx_s2 <= grp_idx;
	end

	always_comb begin
		res = '0;
		for (int g = N_GRP - 1; g >= 0; g--) begin
			if (grp_any_s2[g]) begin
				res.hit   = 1'b1;
				res.where = FPOS_W'(g * GRP_N) + FPOS_W'(grp_idx_s2[g]) + FPOS_W'(1);
			end
		end
	end

endmodule

### rtl/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// ordered list of signed words held in a row of shifting cells
// the result passes the cell compare, group and output registers before it is valid
// one request at a time; the next beat can be taken the cycle after the
// result is taken
// insert and delete shift the cells from the given position on in the accept
// cycle; find runs a two-level first-match encoder over the cell compares
// reset clears the length and control; cell contents stay undefined
// ----------------------------------------------------------------------------
module positional_list_engine_unit import ple_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ple_req_if.sink    req,
	ple_rsp_if.source  rsp
);

	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             v_s1, v_s2;
	logic [1:0]       func_s1, func_s2;
	logic [1:0]       status_s1, status_s2;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [FPOS_W-1:0] out_where_q;

	logic             acc;
	logic [CMP_W-1:0] pos_w, cnt_w;
	logic             full, ins_bad, del_bad, ins_ok, del_ok;
	logic [1:0]       status_in;
	cell_ctrl_t       ctrl;
	word_t            data [DEPTH];
	logic [DEPTH-1:0] match;
	find_res_t        fres;

	assign acc       = req.valid && req.ready;
	assign req.ready = !busy_q;

	assign pos_w   = CMP_W'(req.position);
	assign cnt_w   = CMP_W'(count_q);
	assign full    = (cnt_w >= CMP_W'(DEPTH));
	assign ins_bad = (pos_w == '0) || (pos_w > cnt_w + CMP_W'(1));
	assign del_bad = (pos_w == '0) || (pos_w > cnt_w);
	assign ins_ok  = (req.func == FUNC_INSERT) && !full && !ins_bad;
	assign del_ok  = (req.func == FUNC_DELETE) && !del_bad;

	always_comb begin
		case (req.func)
			FUNC_INSERT: status_in = full ? ST_FULL : (ins_bad ? ST_BADPOS : ST_OK);
			FUNC_DELETE: status_in = del_bad ? ST_BADPOS : ST_OK;
			default:     status_in = ST_OK;
		endcase
	end

	always_comb begin
		ctrl.shift_up   = acc && ins_ok;
		ctrl.shift_down = acc && del_ok;
		ctrl.search     = acc && (req.func == FUNC_FIND);
		ctrl.pos        = IDX_W'(pos_w - CMP_W'(1));
		ctrl.count      = count_q;
		ctrl.value      = req.value;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = data[i+1];
		end
		ple_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.idx   (IDX_W'(i)),
			.left  (left_w),
			.right (right_w),
			.data  (data[i]),
			.match (match[i])
		);
	end

	ple_find u_find (
		.clk   (clk),
		.match (match),
		.res   (fres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
				if (ins_ok) begin
					count_q <= count_q + CNT_W'(1);
				end else if (del_ok) begin
					count_q <= count_q - CNT_W'(1);
				end
			end else if (rsp.valid && rsp.ready) begin
				busy_q <= 1'b0;
			end
			v_s1 <= acc;
			v_s2 <= v_s1;
			if (v_s2) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_s1   <= req.func;
			status_s1 <= status_in;
		end
		func_s2   <= func_s1;
		status_s2 <= status_s1;
		if (v_s2) begin
			if (func_s2 == FUNC_FIND) begin
				out_status_q <= fres.hit ? ST_OK : ST_NOTFOUND;
				out_where_q  <= fres.hit ? fres.where : '0;
			end else begin
				out_status_q <= status_s2;
				out_where_q  <= '0;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.found_position = out_where_q;
	assign rsp.list_length    = FPOS_W'(count_q);
	assign rsp.is_empty       = (count_q == '0);

endmodule
